// ===== rtl/rcam_pkg.sv =====
// Shared constants, types and helpers of the rounded-corner alpha mask.
// Used by the channel interfaces, the curve unit and the top level.
`default_nettype none

package rcam_pkg;

    localparam int COORD_BITS = 10;
    localparam int FRAC_BITS  = 8;
    localparam int ALPHA_BITS = 8;

    // Fixed-point lengths, their squares and signed distances.
    localparam int LEN_W  = COORD_BITS + FRAC_BITS + 1;
    localparam int RAD_W  = 2 * LEN_W;
    localparam int DIST_W = RAD_W + 2;
    localparam int FAC_W  = FRAC_BITS + 1;

    // Curve unit: one root bit per stage, one product stage, one quotient bit per stage.
    localparam int UNIT_LAT   = LEN_W + 1 + RAD_W;
    localparam int PIPE_DEPTH = UNIT_LAT + 5;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = COORD_BITS;

    typedef logic [COORD_BITS-1:0]    t_coord;
    typedef logic [ALPHA_BITS-1:0]    t_alpha;
    typedef logic [LEN_W-1:0]         t_len;
    typedef logic [RAD_W-1:0]         t_rad;
    typedef logic signed [DIST_W-1:0] t_dist;
    typedef logic [FAC_W-1:0]         t_fac;
    typedef logic [CFG_IDX_W-1:0]     t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0]    t_cfg_data;

    localparam t_len FX_ONE  = t_len'(1) << FRAC_BITS;
    localparam t_len FX_HALF = t_len'(1) << (FRAC_BITS - 1);
    localparam t_fac FAC_ONE = t_fac'(1) << FRAC_BITS;

    localparam t_cfg_idx CFG_RADIUS_H      = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_RADIUS_V      = t_cfg_idx'(1);
    localparam t_cfg_idx CFG_CORNER_RIGHT  = t_cfg_idx'(2);
    localparam t_cfg_idx CFG_CORNER_BOTTOM = t_cfg_idx'(3);

    // Radii of one curve; eq selects the plain root instead of root * a / b.
    typedef struct packed {
        t_len a;
        t_len b;
        logic eq;
    } t_curve_cfg;

    function automatic t_rad abs_diff(input t_rad p, input t_rad q);
        return (p > q) ? (p - q) : (q - p);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rcam_if.sv =====
// Valid/ready channel interfaces: pixel requests, alpha results and register writes.
// Depends on rcam_pkg for the payload types.
`default_nettype none

interface rcam_pix_if;
    logic            valid;
    logic            ready;
    rcam_pkg::t_coord pixel_col;
    rcam_pkg::t_coord pixel_row;
    rcam_pkg::t_alpha alpha_in;
    modport source(output valid, pixel_col, pixel_row, alpha_in, input ready);
    modport sink(input valid, pixel_col, pixel_row, alpha_in, output ready);
endinterface

interface rcam_res_if;
    logic            valid;
    logic            ready;
    rcam_pkg::t_alpha alpha_out;
    modport source(output valid, alpha_out, input ready);
    modport sink(input valid, alpha_out, output ready);
endinterface

interface rcam_cfg_if;
    logic               valid;
    logic               ready;
    rcam_pkg::t_cfg_idx  index;
    rcam_pkg::t_cfg_data data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/rcam_curve.sv =====
// Pipelined curve unit: floor(sqrt(radicand)), then optionally times a over b.
// Depends on rcam_pkg; one root bit and one quotient bit are resolved per stage.
`default_nettype none

module rcam_curve (
    input  wire logic                 i_clk,
    input  wire logic                 i_adv,
    input  wire rcam_pkg::t_rad       i_rad,
    input  wire rcam_pkg::t_curve_cfg i_curve,
    output rcam_pkg::t_rad            o_e
);
    localparam int RW = rcam_pkg::LEN_W;
    localparam int NW = rcam_pkg::RAD_W;

    // Square root stages: w_* index 0 is the unit input, index g+1 the output of stage g.
    logic [RW+1:0] r_srem  [0:RW-1];
    logic [RW-1:0] r_sroot [0:RW-1];
    logic [NW-1:0] r_srad  [0:RW-1];
    logic [RW+1:0] w_srem  [0:RW];
    logic [RW-1:0] w_sroot [0:RW];
    logic [NW-1:0] w_srad  [0:RW];

    assign w_srem[0]  = '0;
    assign w_sroot[0] = '0;
    assign w_srad[0]  = i_rad;

    for (genvar g = 0; g < RW; g++) begin : g_sqrt
        logic [RW+1:0] w_rm;
        logic [RW+1:0] w_trial;
        logic          w_ge;

        assign w_srem[g+1]  = r_srem[g];
        assign w_sroot[g+1] = r_sroot[g];
        assign w_srad[g+1]  = r_srad[g];

        assign w_rm    = {w_srem[g][RW-1:0], w_srad[g][NW-1 -: 2]};
        assign w_trial = {w_sroot[g], 2'b01};
        assign w_ge    = (w_rm >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_srem[g]  <= w_ge ? (w_rm - w_trial) : w_rm;
                r_sroot[g] <= {w_sroot[g][RW-2:0], w_ge};
                r_srad[g]  <= {w_srad[g][NW-3:0], 2'b00};
            end
        end
    end

    // Scale by a; for equal radii the root passes and the divisor is one.
    logic [NW-1:0] r_prod;
    logic [NW-1:0] w_prod;
    logic [RW-1:0] w_divisor;

    assign w_prod    = w_sroot[RW] * i_curve.a;
    assign w_divisor = i_curve.eq ? RW'(1) : i_curve.b;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod <= i_curve.eq ? NW'(w_sroot[RW]) : w_prod;
        end
    end

    // Restoring division: the dividend shifts out at the top, quotient bits enter below.
    logic [RW-1:0] r_drem [0:NW-1];
    logic [NW-1:0] r_dn   [0:NW-1];
    logic [RW-1:0] w_drem [0:NW];
    logic [NW-1:0] w_dn   [0:NW];

    assign w_drem[0] = '0;
    assign w_dn[0]   = r_prod;

    for (genvar j = 0; j < NW; j++) begin : g_div
        logic [RW:0] w_rm;
        logic        w_ge;

        assign w_drem[j+1] = r_drem[j];
        assign w_dn[j+1]   = r_dn[j];

        assign w_rm = {w_drem[j], w_dn[j][NW-1]};
        assign w_ge = (w_rm >= {1'b0, w_divisor});

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_drem[j] <= w_ge ? RW'(w_rm - {1'b0, w_divisor}) : RW'(w_rm);
                r_dn[j]   <= {w_dn[j][NW-2:0], w_ge};
            end
        end
    end

    assign o_e = w_dn[NW];

endmodule

`default_nettype wire

// ===== rtl/rounded_corner_alpha_mask_top.sv =====
// Rounded-corner alpha mask: clips one pixel per clock to an anti-aliased corner
// while the output is not stalled; a stalled output freezes the whole pipeline.
// The curve units' bit-per-stage root and quotient pipelines set the depth.
// Reset (synchronous, active low) empties the pipeline and sets radii 1, top-left.
// Depends on rcam_pkg, the channel interfaces and rcam_curve.
`default_nettype none

module rounded_corner_alpha_mask_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rcam_pix_if.sink   i_pix,
    rcam_cfg_if.sink   i_cfg,
    rcam_res_if.source o_res
);
    localparam int FB = rcam_pkg::FRAC_BITS;
    localparam int N  = rcam_pkg::PIPE_DEPTH;
    localparam int K  = 2 + rcam_pkg::UNIT_LAT;

    // Configuration registers.
    rcam_pkg::t_coord r_rh;
    rcam_pkg::t_coord r_rv;
    logic             r_right;
    logic             r_bottom;
    rcam_pkg::t_coord w_wr_rad;

    assign i_cfg.ready = 1'b1;
    assign w_wr_rad    = (i_cfg.data == '0) ? rcam_pkg::t_coord'(1) : i_cfg.data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rh     <= rcam_pkg::t_coord'(1);
            r_rv     <= rcam_pkg::t_coord'(1);
            r_right  <= 1'b0;
            r_bottom <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                rcam_pkg::CFG_RADIUS_H:      r_rh     <= w_wr_rad;
                rcam_pkg::CFG_RADIUS_V:      r_rv     <= w_wr_rad;
                rcam_pkg::CFG_CORNER_RIGHT:  r_right  <= i_cfg.data[0];
                rcam_pkg::CFG_CORNER_BOTTOM: r_bottom <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // Corner geometry; user changes it only while pipeline is empty, unenforced.
    rcam_pkg::t_len       w_rx;
    rcam_pkg::t_len       w_ry;
    rcam_pkg::t_len       w_cx;
    rcam_pkg::t_len       w_cy;
    rcam_pkg::t_curve_cfg w_edge;
    rcam_pkg::t_curve_cfg w_main;

    always_comb begin
        w_rx = rcam_pkg::t_len'({r_rh, {FB{1'b0}}}) - rcam_pkg::FX_HALF;
        w_ry = rcam_pkg::t_len'({r_rv, {FB{1'b0}}}) - rcam_pkg::FX_HALF;
        w_cx = r_right ? '0 : w_rx;
        w_cy = r_bottom ? '0 : w_ry;
        if (r_right) begin
            w_edge.a = (w_rx > rcam_pkg::FX_ONE) ? (w_rx - rcam_pkg::FX_ONE) : '0;
            w_edge.b = (w_ry > rcam_pkg::FX_ONE) ? (w_ry - rcam_pkg::FX_ONE) : '0;
        end else begin
            w_edge.a = w_rx + rcam_pkg::FX_ONE;
            w_edge.b = w_ry + rcam_pkg::FX_ONE;
        end
        w_edge.eq = (w_edge.a == w_edge.b);
        w_main.a  = w_rx;
        w_main.b  = w_ry;
        w_main.eq = (r_rh == r_rv);
    end

    // Pipeline control: every stage moves together unless the result is held.
    logic [N-1:0] r_vld;
    logic         w_adv;

    assign w_adv       = !r_vld[N-1] || o_res.ready;
    assign i_pix.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[N-2:0], i_pix.valid};
        end
    end

    rcam_pkg::t_coord r_col   [0:K];
    rcam_pkg::t_alpha r_alpha [0:K];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_col[0]   <= i_pix.pixel_col;
            r_alpha[0] <= i_pix.alpha_in;
            for (int k = 1; k <= K; k++) begin
                r_col[k]   <= r_col[k-1];
                r_alpha[k] <= r_alpha[k-1];
            end
        end
    end

    // First stage: offsets from the centre.
    logic signed [rcam_pkg::LEN_W:0] w_y;
    rcam_pkg::t_len                  w_xfix;
    rcam_pkg::t_len                  r_mx;
    rcam_pkg::t_len                  r_my;

    assign w_y    = $signed({1'b0, w_cy})
                  - $signed({1'b0, rcam_pkg::t_len'({i_pix.pixel_row, {FB{1'b0}}})});
    assign w_xfix = rcam_pkg::t_len'({i_pix.pixel_col, {FB{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mx <= (w_xfix >= w_cx) ? (w_xfix - w_cx) : (w_cx - w_xfix);
            r_my <= w_y[rcam_pkg::LEN_W] ? rcam_pkg::t_len'(-w_y) : rcam_pkg::t_len'(w_y);
        end
    end

    // Second stage: squares.
    rcam_pkg::t_rad r_mxx;
    rcam_pkg::t_rad r_myy;
    rcam_pkg::t_rad r_bbe;
    rcam_pkg::t_rad r_bbm;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mxx <= r_mx * r_mx;
            r_myy <= r_my * r_my;
            r_bbe <= w_edge.b * w_edge.b;
            r_bbm <= w_main.b * w_main.b;
        end
    end

    // Third stage: radicands for the edge start and for the distance.
    rcam_pkg::t_rad r_rad_e;
    rcam_pkg::t_rad r_rad_m;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rad_e <= rcam_pkg::abs_diff(r_bbe, r_myy);
            r_rad_m <= w_main.eq ? (r_mxx + r_myy) : rcam_pkg::abs_diff(r_bbm, r_myy);
        end
    end

    rcam_pkg::t_rad w_e_edge;
    rcam_pkg::t_rad w_e_main;

    rcam_curve u_edge (
        .i_clk   (i_clk),
        .i_adv   (w_adv),
        .i_rad   (r_rad_e),
        .i_curve (w_edge),
        .o_e     (w_e_edge)
    );

    rcam_curve u_main (
        .i_clk   (i_clk),
        .i_adv   (w_adv),
        .i_rad   (r_rad_m),
        .i_curve (w_main),
        .o_e     (w_e_main)
    );

    // Edge decision and distance become one scale factor, ONE meaning keep.
    rcam_pkg::t_rad  w_colr;
    rcam_pkg::t_dist w_colfix;
    rcam_pkg::t_dist w_cxd;
    rcam_pkg::t_dist w_s;
    rcam_pkg::t_dist w_d;
    logic            w_keep;
    logic            w_clear;
    rcam_pkg::t_fac  w_fac;
    rcam_pkg::t_fac  r_fac;
    rcam_pkg::t_alpha r_f1_alpha;

    always_comb begin
        w_colr   = rcam_pkg::t_rad'(r_col[K]);
        w_colfix = rcam_pkg::t_dist'({r_col[K], {FB{1'b0}}});
        w_cxd    = rcam_pkg::t_dist'(w_cx);
        w_s      = w_cxd - rcam_pkg::t_dist'(w_e_edge);
        // A right corner with a flat inner ellipse never reaches its edge.
        w_keep   = (w_edge.b == '0 && !w_edge.eq) || (w_colr < (w_e_edge >> FB));
        w_clear  = (w_s > 0) && (w_colr < rcam_pkg::t_rad'(w_s >>> FB));
        if (w_main.eq) begin
            w_d = rcam_pkg::t_dist'(w_e_main) - rcam_pkg::t_dist'(w_rx);
        end else if (r_right) begin
            w_d = w_colfix - rcam_pkg::t_dist'(w_e_main);
        end else begin
            w_d = w_cxd - rcam_pkg::t_dist'(w_e_main) - w_colfix;
        end
        priority if (r_right && w_keep) begin
            w_fac = rcam_pkg::FAC_ONE;
        end else if (!r_right && w_clear) begin
            w_fac = '0;
        end else if (w_d < 0) begin
            w_fac = rcam_pkg::FAC_ONE;
        end else if (w_d >= rcam_pkg::t_dist'(rcam_pkg::FX_ONE)) begin
            w_fac = '0;
        end else begin
            w_fac = rcam_pkg::FAC_ONE - rcam_pkg::t_fac'(w_d);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_fac      <= w_fac;
            r_f1_alpha <= r_alpha[K];
        end
    end

    // Output register.
    logic [rcam_pkg::ALPHA_BITS+FB:0] w_scaled;
    rcam_pkg::t_alpha                 r_out;

    assign w_scaled = r_f1_alpha * r_fac;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_scaled[rcam_pkg::ALPHA_BITS+FB-1:FB];
        end
    end

    assign o_res.valid     = r_vld[N-1];
    assign o_res.alpha_out = r_out;

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");

    a_valid_travel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_vld[N-2] |=> r_vld[N-1])
        else $error("request lost before the output register");

    a_factor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[N-2] |-> r_fac <= rcam_pkg::FAC_ONE)
        else $error("scale factor above one");

    a_alpha_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_vld[N-2] |=> r_out <= $past(r_f1_alpha))
        else $error("output alpha exceeds input alpha");

endmodule

`default_nettype wire
